// ===== src/rpwt_pkg.sv =====
package rpwt_pkg;

    // field widths
    localparam int PSN_W      = 32;
    localparam int ACTION_W   = 2;
    localparam int STATUS_W   = 2;
    localparam int MAP_OUT_W  = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_DATA_RCV = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DATA_ACK = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REQ_RCV  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_DATA_PSN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_REQ_PSN  = 2'd1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_ACCEPTED      = 2'd0,
        STAT_DUPLICATE     = 2'd1,
        STAT_OUT_OF_WINDOW = 2'd2,
        STAT_REJECTED      = 2'd3
    } t_status;

    // controller states
    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_SLIDE = 1'b1
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic commit;
    } t_cmd;

endpackage

// ===== src/receiver_psn_window_tracker.sv =====
// channel   direction  handshake                payload
// input     in         i_in_valid / o_in_stall  i_action, i_seq_num
// result    out        o_out_valid / i_out_stall o_status, bases, bitmaps
// config    in         i_cfg_we                 i_cfg_index, i_cfg_data
//
// each transaction has a window check and bit mark in the accept
// cycle, then the run-length count and bitmap shift of the slide unit
// the result waits in an output register; the next transaction is taken in
// the cycle after the slide commits
// a stalled result holds the slide step, so the input stalls as well
// synchronous reset clears both bases and all bitmaps at once, no clear pass
module receiver_psn_window_tracker #(
    parameter int DATA_WINDOW    = 128,
    parameter int REQUEST_WINDOW = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rpwt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rpwt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [rpwt_pkg::ACTION_W-1:0]      i_action,
    input  logic [rpwt_pkg::PSN_W-1:0]         i_seq_num,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [rpwt_pkg::STATUS_W-1:0]      o_status,
    output logic [rpwt_pkg::PSN_W-1:0]         o_data_window_base,
    output logic [rpwt_pkg::PSN_W-1:0]         o_request_window_base,
    output logic [rpwt_pkg::MAP_OUT_W-1:0]     o_data_ack_bits_low,
    output logic [rpwt_pkg::MAP_OUT_W-1:0]     o_data_ack_bits_high,
    output logic [rpwt_pkg::MAP_OUT_W-1:0]     o_data_rcvd_bits_low,
    output logic [rpwt_pkg::MAP_OUT_W-1:0]     o_data_rcvd_bits_high,
    output logic [rpwt_pkg::MAP_OUT_W-1:0]     o_request_rcvd_bits
);
    import rpwt_pkg::*;

    t_cmd w_cmd;

    // sequencing and result handshake
    rpwt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    // window state and result register
    rpwt_dpath #(
        .DATA_WINDOW    (DATA_WINDOW),
        .REQUEST_WINDOW (REQUEST_WINDOW)
    ) u_dpath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (w_cmd),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_action              (i_action),
        .i_seq_num             (i_seq_num),
        .o_status              (o_status),
        .o_data_window_base    (o_data_window_base),
        .o_request_window_base (o_request_window_base),
        .o_data_ack_bits_low   (o_data_ack_bits_low),
        .o_data_ack_bits_high  (o_data_ack_bits_high),
        .o_data_rcvd_bits_low  (o_data_rcvd_bits_low),
        .o_data_rcvd_bits_high (o_data_rcvd_bits_high),
        .o_request_rcvd_bits   (o_request_rcvd_bits)
    );

endmodule

// ===== src/rpwt_slide.sv =====
module rpwt_slide #(
    parameter int W = 128
) (
    input  logic [W-1:0]                  i_map,
    input  logic [rpwt_pkg::PSN_W-1:0]    i_base,
    output logic [$clog2(W+1)-1:0]        o_amount
);
    import rpwt_pkg::*;

    localparam int KW = $clog2(W + 1);

    logic [KW-1:0]    w_run;
    logic [PSN_W-1:0] w_room;

    // length of the run of set bits starting at offset 0
    always_comb begin
        w_run = KW'(W);
        for (int i = W - 1; i >= 0; i--) begin
            if (!i_map[i]) begin
                w_run = KW'(i);
            end
        end
    end

    // never move the base past the largest number
    always_comb begin
        w_room = {PSN_W{1'b1}} - i_base;
        if (PSN_W'(w_run) < w_room) begin
            o_amount = w_run;
        end else begin
            o_amount = w_room[KW-1:0];
        end
    end

endmodule

// ===== src/rpwt_ctrl.sv =====
module rpwt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output rpwt_pkg::t_cmd o_cmd
);
    import rpwt_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SLIDE;
                end
            end
            ST_SLIDE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd.accept = 1'b0;
        o_cmd.commit = 1'b0;
        o_in_stall   = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            ST_SLIDE: begin
                o_cmd.commit = !r_out_valid || !i_out_stall;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // output register occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    // an accepted transaction always goes to the slide step next
    a_accept_to_slide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == ST_SLIDE) && !o_cmd.accept)
        else $error("accepted transaction did not move to slide step");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && r_state == ST_SLIDE) |=> (r_state == ST_SLIDE))
        else $error("slide step committed over a stalled result");

    // a new result only appears after a slide step
    a_result_from_slide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_SLIDE)
        else $error("result appeared without a slide step");
`endif

endmodule

// ===== src/rpwt_dpath.sv =====
module rpwt_dpath #(
    parameter int DATA_WINDOW    = 128,
    parameter int REQUEST_WINDOW = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rpwt_pkg::t_cmd                     i_cmd,
    input  logic                               i_cfg_we,
    input  logic [rpwt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rpwt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [rpwt_pkg::ACTION_W-1:0]      i_action,
    input  logic [rpwt_pkg::PSN_W-1:0]         i_seq_num,
    output logic [rpwt_pkg::STATUS_W-1:0]      o_status,
    output logic [rpwt_pkg::PSN_W-1:0]         o_data_window_base,
    output logic [rpwt_pkg::PSN_W-1:0]         o_request_window_base,
    output logic [rpwt_pkg::MAP_OUT_W-1:0]     o_data_ack_bits_low,
    output logic [rpwt_pkg::MAP_OUT_W-1:0]     o_data_ack_bits_high,
    output logic [rpwt_pkg::MAP_OUT_W-1:0]     o_data_rcvd_bits_low,
    output logic [rpwt_pkg::MAP_OUT_W-1:0]     o_data_rcvd_bits_high,
    output logic [rpwt_pkg::MAP_OUT_W-1:0]     o_request_rcvd_bits
);
    import rpwt_pkg::*;

    localparam int DIW    = $clog2(DATA_WINDOW);
    localparam int RIW    = $clog2(REQUEST_WINDOW);
    localparam int DKW    = $clog2(DATA_WINDOW + 1);
    localparam int RKW    = $clog2(REQUEST_WINDOW + 1);
    localparam int DEXT_W = 2 * MAP_OUT_W;

    // window state
    logic [PSN_W-1:0]          r_data_base, n_data_base;
    logic [PSN_W-1:0]          r_req_base, n_req_base;
    logic [DATA_WINDOW-1:0]    r_drcvd, n_drcvd;
    logic [DATA_WINDOW-1:0]    r_dack, n_dack;
    logic [REQUEST_WINDOW-1:0] r_rrcvd, n_rrcvd;
    logic                      r_slide_data, n_slide_data;
    logic                      r_slide_req, n_slide_req;
    t_status                   r_status, n_status;

    // window checks on the incoming transaction
    logic             w_d_below, w_d_inwin;
    logic [PSN_W-1:0] w_d_off;
    logic [DIW-1:0]   w_d_idx;
    logic             w_d_rcvd;
    logic             w_r_below, w_r_inwin;
    logic [PSN_W-1:0] w_r_off;
    logic [RIW-1:0]   w_r_idx;
    logic             w_r_rcvd;

    logic [DKW-1:0]   w_d_amt;
    logic [RKW-1:0]   w_r_amt;
    logic [DEXT_W-1:0] w_ack_ext, w_rcvd_ext;

    assign w_d_below = i_seq_num < r_data_base;
    assign w_d_off   = i_seq_num - r_data_base;
    assign w_d_inwin = !w_d_below && (w_d_off < PSN_W'(DATA_WINDOW));
    assign w_d_idx   = w_d_off[DIW-1:0];
    assign w_d_rcvd  = w_d_inwin && r_drcvd[w_d_idx];

    assign w_r_below = i_seq_num < r_req_base;
    assign w_r_off   = i_seq_num - r_req_base;
    assign w_r_inwin = !w_r_below && (w_r_off < PSN_W'(REQUEST_WINDOW));
    assign w_r_idx   = w_r_off[RIW-1:0];
    assign w_r_rcvd  = w_r_inwin && r_rrcvd[w_r_idx];

    // run length of acked data entries and received requests
    rpwt_slide #(.W(DATA_WINDOW)) u_data_slide (
        .i_map    (r_dack),
        .i_base   (r_data_base),
        .o_amount (w_d_amt)
    );

    rpwt_slide #(.W(REQUEST_WINDOW)) u_req_slide (
        .i_map    (r_rrcvd),
        .i_base   (r_req_base),
        .o_amount (w_r_amt)
    );

    // next window state
    always_comb begin
        n_data_base  = r_data_base;
        n_req_base   = r_req_base;
        n_drcvd      = r_drcvd;
        n_dack       = r_dack;
        n_rrcvd      = r_rrcvd;
        n_slide_data = r_slide_data;
        n_slide_req  = r_slide_req;
        n_status     = r_status;

        // check and mark step
        if (i_cmd.accept) begin
            n_slide_data = 1'b0;
            n_slide_req  = 1'b0;
            case (i_action)
                ACT_DATA_RCV: begin
                    if (w_d_below || w_d_rcvd) begin
                        n_status = STAT_DUPLICATE;
                    end else if (!w_d_inwin) begin
                        n_status = STAT_OUT_OF_WINDOW;
                    end else begin
                        n_status          = STAT_ACCEPTED;
                        n_drcvd[w_d_idx]  = 1'b1;
                    end
                end
                ACT_DATA_ACK: begin
                    if (!w_d_rcvd) begin
                        n_status = STAT_REJECTED;
                    end else begin
                        n_status         = STAT_ACCEPTED;
                        n_dack[w_d_idx]  = 1'b1;
                        n_slide_data     = 1'b1;
                    end
                end
                ACT_REQ_RCV: begin
                    if (w_r_below || w_r_rcvd) begin
                        n_status = STAT_DUPLICATE;
                    end else if (!w_r_inwin) begin
                        n_status = STAT_OUT_OF_WINDOW;
                    end else begin
                        n_status         = STAT_ACCEPTED;
                        n_rrcvd[w_r_idx] = 1'b1;
                        n_slide_req      = 1'b1;
                    end
                end
                default: begin
                    n_status = STAT_REJECTED;
                end
            endcase
        end

        // base slide step
        if (i_cmd.commit) begin
            if (r_slide_data) begin
                n_data_base = r_data_base + PSN_W'(w_d_amt);
                n_dack      = r_dack >> w_d_amt;
                n_drcvd     = r_drcvd >> w_d_amt;
            end
            if (r_slide_req) begin
                n_req_base = r_req_base + PSN_W'(w_r_amt);
                n_rrcvd    = r_rrcvd >> w_r_amt;
            end
        end

        // register writes load the bases
        if (i_cfg_we) begin
            if (i_cfg_index == CFG_INIT_DATA_PSN) begin
                n_data_base = i_cfg_data[PSN_W-1:0];
            end
            if (i_cfg_index == CFG_INIT_REQ_PSN) begin
                n_req_base = i_cfg_data[PSN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_base  <= '0;
            r_req_base   <= '0;
            r_drcvd      <= '0;
            r_dack       <= '0;
            r_rrcvd      <= '0;
            r_slide_data <= 1'b0;
            r_slide_req  <= 1'b0;
        end else begin
            r_data_base  <= n_data_base;
            r_req_base   <= n_req_base;
            r_drcvd      <= n_drcvd;
            r_dack       <= n_dack;
            r_rrcvd      <= n_rrcvd;
            r_slide_data <= n_slide_data;
            r_slide_req  <= n_slide_req;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    // result register, loaded with the state after the slide
    assign w_ack_ext  = DEXT_W'(n_dack);
    assign w_rcvd_ext = DEXT_W'(n_drcvd);

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_status              <= r_status;
            o_data_window_base    <= n_data_base;
            o_request_window_base <= n_req_base;
            o_data_ack_bits_low   <= w_ack_ext[MAP_OUT_W-1:0];
            o_data_ack_bits_high  <= w_ack_ext[DEXT_W-1:MAP_OUT_W];
            o_data_rcvd_bits_low  <= w_rcvd_ext[MAP_OUT_W-1:0];
            o_data_rcvd_bits_high <= w_rcvd_ext[DEXT_W-1:MAP_OUT_W];
            o_request_rcvd_bits   <= MAP_OUT_W'(n_rrcvd);
        end
    end

`ifndef SYNTHESIS
    // only one window slides per transaction
    a_one_slide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_slide_data, r_slide_req}))
        else $error("both windows marked to slide");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import rpwt_pkg::*;

    localparam int          DATA_SPAN      = 128;
    localparam int          REQ_SPAN       = 64;
    localparam logic [31:0] PSN_TOP        = 32'hFFFF_FFFF;
    localparam int          WATCHDOG_LIMIT = 3000;
    // action code with no meaning in the block
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // one result transaction as seen on the output port
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PSN_W-1:0]    data_base;
        logic [PSN_W-1:0]    req_base;
        logic [127:0]        data_acked;
        logic [127:0]        data_rcvd;
        logic [63:0]         req_rcvd;
    } t_window_view;

    // window state tracker and result checker
    class psn_window_checker;
        logic [PSN_W-1:0] data_base;
        logic [PSN_W-1:0] req_base;
        logic [127:0]     data_rcvd;
        logic [127:0]     data_acked;
        logic [63:0]      req_rcvd;
        t_window_view     expected_views[$];
        int               failures;

        function new();
            data_base  = '0;
            req_base   = '0;
            data_rcvd  = '0;
            data_acked = '0;
            req_rcvd   = '0;
            failures   = 0;
        endfunction

        // a base register write moves the base, bitmaps stay
        function void load_base(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
            if (idx == CFG_INIT_DATA_PSN)
                data_base = value;
            else if (idx == CFG_INIT_REQ_PSN)
                req_base = value;
        endfunction

        function t_status recv_data(logic [31:0] psn);
            logic [31:0] off;
            off = psn - data_base;
            if (psn < data_base)
                return STAT_DUPLICATE;
            if (off < DATA_SPAN && data_rcvd[off[6:0]])
                return STAT_DUPLICATE;
            if ({1'b0, psn} >= {1'b0, data_base} + 33'(DATA_SPAN))
                return STAT_OUT_OF_WINDOW;
            data_rcvd[off[6:0]] = 1'b1;
            return STAT_ACCEPTED;
        endfunction

        function t_status ack_data(logic [31:0] psn);
            logic [31:0] off;
            logic [31:0] room;
            int          run;
            if (psn < data_base)
                return STAT_REJECTED;
            off = psn - data_base;
            if (off >= DATA_SPAN || !data_rcvd[off[6:0]])
                return STAT_REJECTED;
            data_acked[off[6:0]] = 1'b1;
            // slide past the leading run of acked entries, never past the top
            run = 0;
            while (run < DATA_SPAN && data_acked[run])
                run++;
            room = PSN_TOP - data_base;
            if (room < run)
                run = int'(room);
            data_base  = data_base + run;
            data_rcvd  = data_rcvd >> run;
            data_acked = data_acked >> run;
            return STAT_ACCEPTED;
        endfunction

        function t_status recv_request(logic [31:0] psn);
            logic [31:0] off;
            logic [31:0] room;
            int          run;
            if (psn < req_base)
                return STAT_DUPLICATE;
            off = psn - req_base;
            if (off < REQ_SPAN && req_rcvd[off[5:0]])
                return STAT_DUPLICATE;
            if (off >= REQ_SPAN)
                return STAT_OUT_OF_WINDOW;
            req_rcvd[off[5:0]] = 1'b1;
            run = 0;
            while (run < REQ_SPAN && req_rcvd[run])
                run++;
            room = PSN_TOP - req_base;
            if (room < run)
                run = int'(room);
            req_base = req_base + run;
            req_rcvd = req_rcvd >> run;
            return STAT_ACCEPTED;
        endfunction

        // note an accepted input transaction and queue its result
        function void take_transaction(logic [ACTION_W-1:0] action, logic [31:0] psn);
            t_window_view want;
            t_status      st;
            case (action)
                ACT_DATA_RCV: st = recv_data(psn);
                ACT_DATA_ACK: st = ack_data(psn);
                ACT_REQ_RCV:  st = recv_request(psn);
                default:      st = STAT_REJECTED;
            endcase
            want.status     = st;
            want.data_base  = data_base;
            want.req_base   = req_base;
            want.data_acked = data_acked;
            want.data_rcvd  = data_rcvd;
            want.req_rcvd   = req_rcvd;
            expected_views.insert(expected_views.size(), want);
        endfunction

        function void compare_field(string name, logic [127:0] want, logic [127:0] seen);
            if (seen !== want) begin
                $error("%s: expected %h, got %h", name, want, seen);
                failures++;
            end
        endfunction

        // check one accepted result transaction against the oldest prediction
        function void check_view(t_window_view seen);
            t_window_view want;
            if (expected_views.size() == 0) begin
                $error("result transaction with nothing expected");
                failures++;
                return;
            end
            want = expected_views.pop_front();
            compare_field("status", 128'(want.status), 128'(seen.status));
            compare_field("data_window_base", 128'(want.data_base), 128'(seen.data_base));
            compare_field("request_window_base", 128'(want.req_base), 128'(seen.req_base));
            compare_field("data_ack_bits_low", 128'(want.data_acked[63:0]),
                          128'(seen.data_acked[63:0]));
            compare_field("data_ack_bits_high", 128'(want.data_acked[127:64]),
                          128'(seen.data_acked[127:64]));
            compare_field("data_rcvd_bits_low", 128'(want.data_rcvd[63:0]),
                          128'(seen.data_rcvd[63:0]));
            compare_field("data_rcvd_bits_high", 128'(want.data_rcvd[127:64]),
                          128'(seen.data_rcvd[127:64]));
            compare_field("request_rcvd_bits", 128'(want.req_rcvd), 128'(seen.req_rcvd));
        endfunction

        // lowest received offset not yet acked, -1 if none
        function int oldest_unacked();
            for (int i = 0; i < DATA_SPAN; i++) begin
                if (data_rcvd[i] && !data_acked[i])
                    return i;
            end
            return -1;
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [ACTION_W-1:0]   i_action;
    logic [PSN_W-1:0]      i_seq_num;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [STATUS_W-1:0]   o_status;
    logic [PSN_W-1:0]      o_data_window_base;
    logic [PSN_W-1:0]      o_request_window_base;
    logic [MAP_OUT_W-1:0]  o_data_ack_bits_low;
    logic [MAP_OUT_W-1:0]  o_data_ack_bits_high;
    logic [MAP_OUT_W-1:0]  o_data_rcvd_bits_low;
    logic [MAP_OUT_W-1:0]  o_data_rcvd_bits_high;
    logic [MAP_OUT_W-1:0]  o_request_rcvd_bits;

    psn_window_checker model = new();
    bit                calm;
    bit                long_hold;
    int                quiet_cycles = 0;

    receiver_psn_window_tracker dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_action              (i_action),
        .i_seq_num             (i_seq_num),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_status              (o_status),
        .o_data_window_base    (o_data_window_base),
        .o_request_window_base (o_request_window_base),
        .o_data_ack_bits_low   (o_data_ack_bits_low),
        .o_data_ack_bits_high  (o_data_ack_bits_high),
        .o_data_rcvd_bits_low  (o_data_rcvd_bits_low),
        .o_data_rcvd_bits_high (o_data_rcvd_bits_high),
        .o_request_rcvd_bits   (o_request_rcvd_bits)
    );

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // result side: random stall per transaction, one long hold on request
    initial begin
        int hold;
        bit hold_done;
        hold_done   = 1'b0;
        i_out_stall <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (long_hold && !hold_done) begin
                hold      = 120;
                hold_done = 1'b1;
            end else if (calm) begin
                hold = 0;
            end else begin
                hold = $urandom_range(0, 14);
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
            model.check_view('{o_status, o_data_window_base, o_request_window_base,
                               {o_data_ack_bits_high, o_data_ack_bits_low},
                               {o_data_rcvd_bits_high, o_data_rcvd_bits_low},
                               o_request_rcvd_bits});
        end
    end

    // offer one input transaction, after a random gap unless calm
    task automatic offer(logic [ACTION_W-1:0] action, logic [PSN_W-1:0] psn);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= action;
        i_seq_num  <= psn;
        do @(posedge i_clk); while (o_in_stall);
        model.take_transaction(action, psn);
    endtask

    // mostly well-formed traffic near the window bases, some noise
    task automatic pick_item(output logic [ACTION_W-1:0] action,
                             output logic [PSN_W-1:0] psn);
        int roll;
        int off;
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            action = ACT_DATA_RCV;
            off    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 140)
                                                 : $urandom_range(0, 24);
            psn    = model.data_base + off;
        end else if (roll < 70) begin
            action = ACT_DATA_ACK;
            off    = model.oldest_unacked();
            if (off < 0 || $urandom_range(0, 3) == 0)
                off = $urandom_range(0, 31);
            psn = model.data_base + off;
        end else if (roll < 88) begin
            action = ACT_REQ_RCV;
            off    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 70)
                                                 : $urandom_range(0, 12);
            psn    = model.req_base + off;
        end else if (roll < 93) begin
            action = ACTION_W'($urandom_range(0, 2));
            psn    = ((action == ACT_REQ_RCV) ? model.req_base : model.data_base)
                     - $urandom_range(1, 4);
        end else if (roll < 97) begin
            action = ACTION_W'($urandom_range(0, 2));
            psn    = $urandom;
        end else begin
            action = ACT_UNUSED;
            psn    = $urandom;
        end
    endtask

    task automatic run_random(int count);
        logic [ACTION_W-1:0] action;
        logic [PSN_W-1:0]    psn;
        repeat (count) begin
            pick_item(action, psn);
            offer(action, psn);
        end
        i_in_valid <= 1'b0;
    endtask

    // wait until every predicted result has come and the block is idle
    task automatic settle();
        while (model.expected_views.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_bases(logic [PSN_W-1:0] data_psn, logic [PSN_W-1:0] req_psn);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_INIT_DATA_PSN;
        i_cfg_data  <= data_psn;
        @(posedge i_clk);
        model.load_base(CFG_INIT_DATA_PSN, data_psn);
        i_cfg_index <= CFG_INIT_REQ_PSN;
        i_cfg_data  <= req_psn;
        @(posedge i_clk);
        model.load_base(CFG_INIT_REQ_PSN, req_psn);
        i_cfg_we <= 1'b0;
    endtask

    // main sequence
    initial begin
        calm         = 1'b0;
        long_hold    = 1'b0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_INIT_DATA_PSN;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_action    <= ACT_DATA_RCV;
        i_seq_num   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: window edges, duplicates, rejected acks, slides
        offer(ACT_DATA_RCV, 32'd0);
        offer(ACT_DATA_RCV, 32'd0);
        offer(ACT_DATA_RCV, 32'd127);
        offer(ACT_DATA_RCV, 32'd128);
        offer(ACT_DATA_RCV, PSN_TOP);
        offer(ACT_DATA_ACK, 32'd5);
        offer(ACT_DATA_ACK, 32'd200);
        offer(ACT_DATA_ACK, 32'd127);
        offer(ACT_DATA_ACK, 32'd127);
        offer(ACT_DATA_ACK, 32'd0);
        offer(ACT_DATA_RCV, 32'd0);
        offer(ACT_DATA_ACK, 32'd0);
        offer(ACT_DATA_RCV, 32'd64);
        offer(ACT_REQ_RCV, 32'd1);
        offer(ACT_REQ_RCV, 32'd0);
        offer(ACT_REQ_RCV, 32'd1);
        offer(ACT_REQ_RCV, 32'd65);
        offer(ACT_REQ_RCV, 32'd66);
        offer(ACT_REQ_RCV, 32'd65);
        offer(ACT_UNUSED, PSN_TOP);
        i_in_valid <= 1'b0;

        // bases close to the top so random traffic pushes them to the limit
        settle();
        set_bases(32'hFFFF_FFA0, 32'hFFFF_FFD0);
        run_random(150);

        // bases at the top: offset zero stays marked
        settle();
        set_bases(PSN_TOP, PSN_TOP);
        offer(ACT_DATA_RCV, PSN_TOP);
        offer(ACT_DATA_ACK, PSN_TOP);
        offer(ACT_DATA_ACK, PSN_TOP);
        offer(ACT_DATA_RCV, PSN_TOP - 1);
        offer(ACT_REQ_RCV, PSN_TOP);
        offer(ACT_REQ_RCV, PSN_TOP);
        run_random(30);

        // arbitrary bases; result side holds off while input keeps coming
        settle();
        set_bases($urandom, $urandom);
        long_hold = 1'b1;
        calm      = 1'b1;
        run_random(60);
        calm = 1'b0;
        run_random(140);

        // back to zero bases
        settle();
        set_bases('0, '0);
        run_random(200);

        settle();
        repeat (10) @(posedge i_clk);
        if (model.failures == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
src/rpwt_pkg.sv
src/rpwt_slide.sv
src/rpwt_ctrl.sv
src/rpwt_dpath.sv
src/receiver_psn_window_tracker.sv
tb/tb.sv
